// ===== design/see_pkg.sv =====
// ----------------------------------------------------------------------------
// see_pkg
// Shared types and constants for the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
package see_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int VALUE_W     = 32;

	localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_ADD  = 2'd1,
		OP_MUL  = 2'd2,
		OP_BAD  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

// ===== design/see_cell.sv =====
// ----------------------------------------------------------------------------
// see_cell
// One stack entry; shifts down on a push and up on an operator.
// ----------------------------------------------------------------------------
module see_cell
	import see_pkg::*;
(
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic signed [VALUE_W-1:0] from_above,
	input  logic signed [VALUE_W-1:0] from_below,
	output logic signed [VALUE_W-1:0] entry
);

	logic signed [VALUE_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_above;
		end else if (ctl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

// ===== design/see_alu.sv =====
// ----------------------------------------------------------------------------
// see_alu
// Registered Q16.16 sum and product of the two top entries, saturated.
// ----------------------------------------------------------------------------
module see_alu
	import see_pkg::*;
(
	input  logic                      clk,
	input  logic                      load,
	input  logic signed [VALUE_W-1:0] first,
	input  logic signed [VALUE_W-1:0] second,
	input  logic                      sel_mul,
	output logic signed [VALUE_W-1:0] result
);

	logic signed [VALUE_W:0]       sum_s1;
	logic signed [2*VALUE_W-1:0]   prod_s1;
	logic signed [VALUE_W-1:0]     sum_sat;
	logic signed [VALUE_W-1:0]     prod_sat;
	logic [VALUE_W/2:0]            prod_high;

	always_ff @(posedge clk) begin
		if (load) begin
			sum_s1  <= {first[VALUE_W-1], first} + {second[VALUE_W-1], second};
			prod_s1 <= first * second;
		end
	end

	// The shift by 16 floors, which is rounding toward minus infinity.
	assign prod_high = prod_s1[2*VALUE_W-1:VALUE_W+VALUE_W/2-1];

	always_comb begin
		if (sum_s1[VALUE_W] != sum_s1[VALUE_W-1]) begin
			sum_sat = sum_s1[VALUE_W] ? Q_MIN : Q_MAX;
		end else begin
			sum_sat = sum_s1[VALUE_W-1:0];
		end
		if ((prod_high != '0) && (prod_high != '1)) begin
			prod_sat = prod_s1[2*VALUE_W-1] ? Q_MIN : Q_MAX;
		end else begin
			prod_sat = prod_s1[VALUE_W+VALUE_W/2-1:VALUE_W/2];
		end
		result = sel_mul ? prod_sat : sum_sat;
	end

endmodule

// ===== design/stack_expression_evaluator.sv =====
// A token is accepted when start is high and busy is low; busy is high for the
// following cycle while the registered multiply finishes and the stack cells
// shift, and the result word appears on the cycle after that with valid high
// for exactly one cycle. A new token is not accepted while busy is high. The
// result cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// stack_expression_evaluator
// Prefix expression evaluator on a row of stack cells, signed Q16.16 values.
// ----------------------------------------------------------------------------
module stack_expression_evaluator
	import see_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      valid,
	output logic [1:0]                status,
	output logic signed [VALUE_W-1:0] top_value,
	output logic [DEPTH_W-1:0]        stack_depth,
	output logic                      operator_seen,
	output logic                      done_res
);

	logic                      busy_s1;
	opcode_t                   op_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      last_s1;

	logic [DEPTH_W-1:0]        depth_q;
	status_t                   error_q;
	logic                      any_op_q;

	logic                      valid_q;
	status_t                   status_q;
	logic signed [VALUE_W-1:0] top_q;
	logic [DEPTH_W-1:0]        depth_out_q;
	logic                      op_seen_q;
	logic                      done_q;

	logic                      accept;
	logic                      err_ok;
	logic                      push_ok;
	logic                      oper_ok;
	status_t                   err_n;
	logic [DEPTH_W-1:0]        depth_n;
	logic                      any_op_n;
	logic signed [VALUE_W-1:0] top_n;
	logic signed [VALUE_W-1:0] alu_result;
	cell_ctl_t                 ctl;

	logic signed [VALUE_W-1:0] entry [STACK_DEPTH];

	assign accept = start && !busy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode_t'(opcode);
			value_s1 <= value;
			last_s1  <= last;
		end
	end

	see_alu u_alu (
		.clk     (clk),
		.load    (accept),
		.first   (entry[0]),
		.second  (entry[1]),
		.sel_mul (op_s1 == OP_MUL),
		.result  (alu_result)
	);

	always_comb begin
		err_ok  = (error_q == ST_OK);
		push_ok = err_ok && (op_s1 == OP_PUSH) && (depth_q < DEPTH_W'(STACK_DEPTH));
		oper_ok = err_ok && ((op_s1 == OP_ADD) || (op_s1 == OP_MUL))
			&& (depth_q >= DEPTH_W'(2));
		err_n = error_q;
		if (err_ok) begin
			case (op_s1)
				OP_PUSH: err_n = push_ok ? ST_OK : ST_FULL;
				OP_ADD,
				OP_MUL:  err_n = oper_ok ? ST_OK : ST_FEW;
				default: err_n = ST_BAD;
			endcase
		end
		if (push_ok) begin
			depth_n = depth_q + DEPTH_W'(1);
		end else if (oper_ok) begin
			depth_n = depth_q - DEPTH_W'(1);
		end else begin
			depth_n = depth_q;
		end
		any_op_n = any_op_q || oper_ok;
		if (oper_ok) begin
			top_n = alu_result;
		end else if (push_ok) begin
			top_n = value_s1;
		end else if (depth_q != '0) begin
			top_n = entry[0];
		end else begin
			top_n = '0;
		end
		ctl.push = busy_s1 && push_ok;
		ctl.pop  = busy_s1 && oper_ok;
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic signed [VALUE_W-1:0] above;
		logic signed [VALUE_W-1:0] below;
		if (i == 0) begin : g_top
			assign above = value_s1;
			assign below = alu_result;
		end else if (i == STACK_DEPTH - 1) begin : g_bottom
			assign above = entry[i-1];
			assign below = entry[i];
		end else begin : g_mid
			assign above = entry[i-1];
			assign below = entry[i+1];
		end
		see_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.entry      (entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			error_q  <= ST_OK;
			any_op_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= busy_s1;
			if (busy_s1) begin
				if (last_s1) begin
					depth_q  <= '0;
					error_q  <= ST_OK;
					any_op_q <= 1'b0;
				end else begin
					depth_q  <= depth_n;
					error_q  <= err_n;
					any_op_q <= any_op_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			status_q    <= err_n;
			top_q       <= top_n;
			depth_out_q <= depth_n;
			op_seen_q   <= any_op_n && (err_n == ST_OK);
			done_q      <= last_s1;
		end
	end

	assign busy          = busy_s1;
	assign valid         = valid_q;
	assign status        = status_q;
	assign top_value     = top_q;
	assign stack_depth   = depth_out_q;
	assign operator_seen = op_seen_q;
	assign done_res      = done_q;

	a_token_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && valid)
		else $error("token did not finish in two cycles");

	a_valid_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result word without a token");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_error_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status != ST_OK) |-> !operator_seen)
		else $error("operator flag set with an error");

	a_error_holds_depth: assert property (@(posedge clk) disable iff (!arst_n)
		busy && (error_q != ST_OK) && !last_s1 |=> $stable(depth_q))
		else $error("stack changed while an error was latched");

endmodule
